FILE: rtl/icmpec_pkg.sv
// Package for the ICMP echo classifier: verdict codes, header offsets,
// the message summary handed from front to back, and the ones-complement add.
// Depends on nothing.
package icmpec_pkg;

   localparam int MAX_MESSAGE_BYTES_DEFAULT = 1480;
   localparam int HEADER_BYTES = 8;
   localparam int QUEUE_DEPTH = 2;  // power of two
   localparam int DATA_LEN_WIDTH = 11;

   localparam logic [1:0] VERDICT_MALFORMED   = 2'd0;
   localparam logic [1:0] VERDICT_UNSUPPORTED = 2'd1;
   localparam logic [1:0] VERDICT_REQUEST     = 2'd2;
   localparam logic [1:0] VERDICT_REPLY       = 2'd3;

   localparam logic [7:0] TYPE_ECHO_REQUEST = 8'd8;
   localparam logic [7:0] TYPE_ECHO_REPLY   = 8'd0;

   localparam int OFS_TYPE     = 0;
   localparam int OFS_CODE     = 1;
   localparam int OFS_IDENT_HI = 4;
   localparam int OFS_IDENT_LO = 5;
   localparam int OFS_SEQ_HI   = 6;
   localparam int OFS_SEQ_LO   = 7;

   // Everything the back end needs to decide on one finished message.
   typedef struct packed {
      logic                      len_ok;
      logic                      odd_pad;
      logic [15:0]               sum;
      logic [7:0]                held;
      logic [7:0]                msg_type;
      logic [7:0]                code;
      logic [15:0]               ident;
      logic [15:0]               seq;
      logic [DATA_LEN_WIDTH-1:0] data_len;
   } msg_sum_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_stat_type;

   function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

endpackage

FILE: rtl/icmpec_if.sv
// Request and response channel interfaces of the ICMP echo classifier.
// Depends on icmpec_pkg for the data length width.
interface icmpec_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface icmpec_rsp_if import icmpec_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic [1:0]                verdict;
   logic [15:0]               echo_identifier;
   logic [15:0]               echo_sequence;
   logic [DATA_LEN_WIDTH-1:0] echo_data_length;

   modport source (output valid, output verdict, output echo_identifier,
                   output echo_sequence, output echo_data_length, input ready);
   modport sink   (input valid, input verdict, input echo_identifier,
                   input echo_sequence, input echo_data_length, output ready);
endinterface

FILE: rtl/icmpec_front.sv
// Front end: counts bytes, accumulates the checksum and captures header fields.
// Depends on icmpec_pkg; pushes one summary per message into the queue.
module icmpec_front import icmpec_pkg::*; #(
   parameter int MAX_MESSAGE_BYTES = MAX_MESSAGE_BYTES_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  logic [7:0]    data_byte,
   input  logic          last_byte,
   output logic          push,
   output msg_sum_type   summary
);

   localparam int CNT_W = $clog2(MAX_MESSAGE_BYTES + 2);
   localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_MESSAGE_BYTES);
   localparam logic [CNT_W-1:0] CNT_OVER = CNT_W'(MAX_MESSAGE_BYTES + 1);
   localparam logic [CNT_W-1:0] CNT_HDR  = CNT_W'(HEADER_BYTES);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [15:0]      sum_ff, sum_in;
   logic [7:0]       held_ff, held_in;
   logic [7:0]       type_ff, type_in;
   logic [7:0]       code_ff, code_in;
   logic [15:0]      ident_ff, ident_in;
   logic [15:0]      seq_ff, seq_in;
   logic [CNT_W-1:0] data_len_w;

   always_comb begin
      cnt_in   = cnt_ff;
      sum_in   = sum_ff;
      held_in  = held_ff;
      type_in  = type_ff;
      code_in  = code_ff;
      ident_in = ident_ff;
      seq_in   = seq_ff;
      if (cnt_ff < CNT_MAX) begin
         case (cnt_ff)
            CNT_W'(OFS_TYPE):     type_in = data_byte;
            CNT_W'(OFS_CODE):     code_in = data_byte;
            CNT_W'(OFS_IDENT_HI): ident_in[15:8] = data_byte;
            CNT_W'(OFS_IDENT_LO): ident_in[7:0] = data_byte;
            CNT_W'(OFS_SEQ_HI):   seq_in[15:8] = data_byte;
            CNT_W'(OFS_SEQ_LO):   seq_in[7:0] = data_byte;
            default: ;
         endcase
         if (!cnt_ff[0]) begin
            held_in = data_byte;
         end else begin
            sum_in = ones_add(sum_ff, {held_ff, data_byte});
         end
         cnt_in = cnt_ff + CNT_W'(1);
      end else begin
         cnt_in = CNT_OVER;
      end
   end

   assign data_len_w = cnt_in - CNT_HDR;

   always_comb begin
      summary.len_ok   = (cnt_in >= CNT_HDR) && (cnt_in <= CNT_MAX);
      summary.odd_pad  = cnt_in[0] && (cnt_in <= CNT_MAX);
      summary.sum      = sum_in;
      summary.held     = held_in;
      summary.msg_type = type_in;
      summary.code     = code_in;
      summary.ident    = ident_in;
      summary.seq      = seq_in;
      summary.data_len = DATA_LEN_WIDTH'(data_len_w);
   end

   assign push = accept && last_byte;

   always_ff @(posedge clock) begin
      if (reset || push) begin
         cnt_ff   <= '0;
         sum_ff   <= '0;
         held_ff  <= '0;
         type_ff  <= '0;
         code_ff  <= '0;
         ident_ff <= '0;
         seq_ff   <= '0;
      end else if (accept) begin
         cnt_ff   <= cnt_in;
         sum_ff   <= sum_in;
         held_ff  <= held_in;
         type_ff  <= type_in;
         code_ff  <= code_in;
         ident_ff <= ident_in;
         seq_ff   <= seq_in;
      end
   end

endmodule

FILE: rtl/icmpec_queue.sv
// Small register queue of message summaries between front and back.
// Depends on icmpec_pkg for the summary type and the queue depth.
module icmpec_queue import icmpec_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  msg_sum_type    push_data,
   input  logic           pop,
   output msg_sum_type    pop_data,
   output queue_stat_type status
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   msg_sum_type      entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign status.full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign status.not_empty = (count_ff != '0);
   assign pop_data         = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

FILE: rtl/icmpec_back.sv
// Back end: finishes the checksum, decides the verdict and holds the response.
// Depends on icmpec_pkg and the response interface in icmpec_if.sv.
module icmpec_back import icmpec_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         q_not_empty,
   input  msg_sum_type  q_data,
   output logic         pop,
   icmpec_rsp_if.source rsp
);

   logic                      valid_ff;
   logic [1:0]                verdict_ff, verdict_in;
   logic [15:0]               ident_ff, ident_in;
   logic [15:0]               seq_ff, seq_in;
   logic [DATA_LEN_WIDTH-1:0] len_ff, len_in;
   logic [15:0]               sum_f;
   logic                      is_echo;

   assign pop = q_not_empty && (!valid_ff || rsp.ready);

   always_comb begin
      sum_f = q_data.odd_pad ? ones_add(q_data.sum, {q_data.held, 8'h00}) : q_data.sum;
      if (!q_data.len_ok || (sum_f != 16'hFFFF)) begin
         verdict_in = VERDICT_MALFORMED;
      end else if ((q_data.msg_type != TYPE_ECHO_REQUEST) &&
                   (q_data.msg_type != TYPE_ECHO_REPLY)) begin
         verdict_in = VERDICT_UNSUPPORTED;
      end else if (q_data.code != 8'h00) begin
         verdict_in = VERDICT_MALFORMED;
      end else if (q_data.msg_type == TYPE_ECHO_REQUEST) begin
         verdict_in = VERDICT_REQUEST;
      end else begin
         verdict_in = VERDICT_REPLY;
      end
      is_echo  = (verdict_in == VERDICT_REQUEST) || (verdict_in == VERDICT_REPLY);
      ident_in = is_echo ? q_data.ident : '0;
      seq_in   = is_echo ? q_data.seq : '0;
      len_in   = is_echo ? q_data.data_len : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         verdict_ff <= verdict_in;
         ident_ff   <= ident_in;
         seq_ff     <= seq_in;
         len_ff     <= len_in;
      end
   end

   assign rsp.valid            = valid_ff;
   assign rsp.verdict          = verdict_ff;
   assign rsp.echo_identifier  = ident_ff;
   assign rsp.echo_sequence    = seq_ff;
   assign rsp.echo_data_length = len_ff;

endmodule

FILE: rtl/icmpec_echo_classifier_top.sv
// ICMP echo classifier: a message is presented one byte per request, header
// first, with last_byte set on its final byte. The block takes one byte every
// clock for as long as its internal queue of finished messages has room; the
// front end counts bytes, folds big-endian byte pairs into a ones-complement
// sum and captures type, code, identifier and sequence, all in the cycle the
// byte is accepted. On the final byte a summary enters a two-entry queue, and
// the back end turns it into one response: verdict, identifier, sequence and
// echo data length (the last three are zero unless the verdict is an echo
// request or reply). The summary passes through the queue into the response
// register, and the response is presented from that register until taken;
// while it waits, the queue absorbs further finished messages, so the byte
// path stalls only when two summaries are already queued behind an untaken
// response. Messages longer than MAX_MESSAGE_BYTES are counted to one past the
// limit and reported malformed.
// Depends on icmpec_pkg, icmpec_if.sv, icmpec_front, icmpec_queue, icmpec_back.
module icmp_echo_classifier import icmpec_pkg::*; #(
   parameter int MAX_MESSAGE_BYTES = MAX_MESSAGE_BYTES_DEFAULT
) (
   input logic          clock,
   input logic          reset,
   icmpec_req_if.sink   req_chan,
   icmpec_rsp_if.source rsp_chan
);

   logic           req_accept;
   logic           q_push;
   logic           q_pop;
   msg_sum_type    q_in;
   msg_sum_type    q_out;
   queue_stat_type q_stat;

   // Bytes are taken whenever the queue can hold one more finished message.
   assign req_chan.ready = !q_stat.full;
   assign req_accept     = req_chan.valid && req_chan.ready;

   icmpec_front #(
      .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .data_byte (req_chan.data_byte),
      .last_byte (req_chan.last_byte),
      .push      (q_push),
      .summary   (q_in)
   );

   icmpec_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .pop_data  (q_out),
      .status    (q_stat)
   );

   icmpec_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_stat.not_empty),
      .q_data      (q_out),
      .pop         (q_pop),
      .rsp         (rsp_chan)
   );

   // A finished message must never be pushed into a full queue.
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_stat.full)
      else $error("summary pushed into full queue");

   // The back end only pops a summary that is actually there.
   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_stat.not_empty)
      else $error("pop from empty queue");

   // Non-echo verdicts carry all-zero echo fields.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.verdict == VERDICT_MALFORMED ||
                          rsp_chan.verdict == VERDICT_UNSUPPORTED))
      |-> (rsp_chan.echo_identifier == '0 && rsp_chan.echo_sequence == '0 &&
           rsp_chan.echo_data_length == '0))
      else $error("non-echo response with nonzero echo fields");

   // No response is pending right after reset.
   assert property (@(posedge clock) reset |=> !rsp_chan.valid)
      else $error("response valid after reset");

endmodule

FILE: verif/tb.sv
// Self-checking bench for icmp_echo_classifier: builds ICMP messages, streams
// them byte by byte and checks every verdict against an in-bench classifier.
// Depends on icmpec_pkg and the channel interfaces in rtl/icmpec_if.sv.
`timescale 1ns / 1ps

module tb;
   import icmpec_pkg::*;

   localparam int MSG_LIMIT = MAX_MESSAGE_BYTES_DEFAULT;

   // One expected or observed response.
   typedef struct packed {
      logic [1:0]                verdict;
      logic [15:0]               ident;
      logic [15:0]               seq;
      logic [DATA_LEN_WIDTH-1:0] data_len;
   } echo_result_type;

   // One request waiting to be driven. The hold flag sits on the first byte of
   // a message and makes the sender wait until every response has come back.
   typedef struct {
      logic [7:0] data;
      logic       fin;
      bit         hold;
   } stream_byte_type;

   logic clock = 1'b0;
   logic reset;

   icmpec_req_if req_bus();
   icmpec_rsp_if rsp_bus();

   icmp_echo_classifier #(
      .MAX_MESSAGE_BYTES(MSG_LIMIT)
   ) uut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_bus.sink),
      .rsp_chan(rsp_bus.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Bytes still to be sent, and the verdicts that accepted messages must produce.
   stream_byte_type byte_stream[$];
   echo_result_type awaited_verdicts[$];

   int error_count = 0;
   int bytes_accepted = 0;
   int msgs_accepted = 0;
   int responses_checked = 0;
   int verdict_tally[4] = '{0, 0, 0, 0};

   // Shadow copy of the classifier state. It mirrors what the block has
   // absorbed from the message currently in flight.
   logic [10:0] seen_count = '0;
   logic [15:0] running_sum = '0;
   logic [7:0]  pair_high = '0;
   logic [7:0]  msg_type = '0;
   logic [7:0]  msg_code = '0;
   logic [15:0] msg_ident = '0;
   logic [15:0] msg_seq = '0;

   // Ones-complement 16-bit add with end-around carry.
   function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

   // Takes one accepted byte into the shadow state. On the final byte of a
   // message it returns 1 with the verdict the block has to give, and then
   // clears the shadow state for the next message.
   function automatic bit absorb_byte(input logic [7:0] b, input logic fin,
                                      output echo_result_type res);
      logic [15:0] total;
      logic [1:0]  v;
      if (seen_count < MSG_LIMIT) begin
         case (int'(seen_count))
            OFS_TYPE:     msg_type = b;
            OFS_CODE:     msg_code = b;
            OFS_IDENT_HI: msg_ident[15:8] = b;
            OFS_IDENT_LO: msg_ident[7:0] = b;
            OFS_SEQ_HI:   msg_seq[15:8] = b;
            OFS_SEQ_LO:   msg_seq[7:0] = b;
            default: ;
         endcase
         // Even offsets open a big-endian pair, odd offsets close it.
         if (!seen_count[0]) begin
            pair_high = b;
         end else begin
            running_sum = fold_add(running_sum, {pair_high, b});
         end
         seen_count = seen_count + 11'd1;
      end else begin
         // Past the limit the bytes are only counted, and the count saturates.
         seen_count = 11'(MSG_LIMIT + 1);
      end
      res = '0;
      if (!fin) begin
         return 1'b0;
      end
      total = running_sum;
      // An unfinished pair is closed with a zero low byte.
      if (seen_count[0] && seen_count <= MSG_LIMIT) begin
         total = fold_add(total, {pair_high, 8'h00});
      end
      if (seen_count < HEADER_BYTES || seen_count > MSG_LIMIT || total != 16'hFFFF) begin
         v = VERDICT_MALFORMED;
      end else if (msg_type != TYPE_ECHO_REQUEST && msg_type != TYPE_ECHO_REPLY) begin
         v = VERDICT_UNSUPPORTED;
      end else if (msg_code != 8'd0) begin
         v = VERDICT_MALFORMED;
      end else if (msg_type == TYPE_ECHO_REQUEST) begin
         v = VERDICT_REQUEST;
      end else begin
         v = VERDICT_REPLY;
      end
      res.verdict = v;
      if (v == VERDICT_REQUEST || v == VERDICT_REPLY) begin
         res.ident = msg_ident;
         res.seq = msg_seq;
         res.data_len = DATA_LEN_WIDTH'(seen_count - 11'(HEADER_BYTES));
      end
      seen_count = '0;
      running_sum = '0;
      pair_high = '0;
      msg_type = '0;
      msg_code = '0;
      msg_ident = '0;
      msg_seq = '0;
      return 1'b1;
   endfunction

   // Idle length for either side. Most gaps are zero or short, a few are long,
   // and now and then a quiet stretch with no idling at all is started.
   function automatic int pick_gap(inout int quiet_left);
      int r;
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
         quiet_left = $urandom_range(30, 150);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // Builds one message and appends its bytes to the stream. With seal set the
   // checksum field is filled in so that the message sums to all ones; damage
   // then flips one random bit somewhere, and blank zeroes the payload.
   task automatic queue_message(input logic [7:0] t, input logic [7:0] c,
                                input logic [15:0] id, input logic [15:0] sq,
                                input int len, input bit seal, input bit damage,
                                input bit blank, input bit hold);
      logic [7:0]      msg [];
      logic [15:0]     acc;
      int              span;
      int              pos;
      stream_byte_type sb;
      msg = new[len];
      foreach (msg[i]) msg[i] = blank ? 8'h00 : 8'($urandom);
      if (len > OFS_TYPE) msg[OFS_TYPE] = t;
      if (len > OFS_CODE) msg[OFS_CODE] = c;
      if (len > OFS_IDENT_HI) msg[OFS_IDENT_HI] = id[15:8];
      if (len > OFS_IDENT_LO) msg[OFS_IDENT_LO] = id[7:0];
      if (len > OFS_SEQ_HI) msg[OFS_SEQ_HI] = sq[15:8];
      if (len > OFS_SEQ_LO) msg[OFS_SEQ_LO] = sq[7:0];
      if (seal && len >= 4) begin
         msg[2] = 8'h00;
         msg[3] = 8'h00;
         acc = '0;
         span = (len < MSG_LIMIT) ? len : MSG_LIMIT;
         for (pos = 0; pos < span; pos += 2) begin
            acc = fold_add(acc, {msg[pos], (pos + 1 < span) ? msg[pos + 1] : 8'h00});
         end
         {msg[2], msg[3]} = ~acc;
      end
      if (damage && len > 0) begin
         pos = $urandom_range(0, len - 1);
         msg[pos] = msg[pos] ^ 8'(1 << $urandom_range(0, 7));
      end
      for (pos = 0; pos < len; pos++) begin
         sb.data = msg[pos];
         sb.fin = (pos == len - 1);
         sb.hold = hold && (pos == 0);
         byte_stream.push_back(sb);
      end
   endtask

   // Request driver. Each request carries one byte; the expected verdict is
   // computed at the edge where the block takes the final byte of a message.
   // A request that is not taken is held unchanged, and valid gets at most one
   // assignment per edge.
   int send_gap = 0;
   int send_quiet = 0;

   always @(posedge clock) begin : drive_requests
      stream_byte_type sb;
      echo_result_type res;
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            bytes_accepted++;
            if (absorb_byte(req_bus.data_byte, req_bus.last_byte, res)) begin
               awaited_verdicts.push_back(res);
               msgs_accepted++;
            end
         end
         if (req_bus.valid && !req_bus.ready) begin
            // Still waiting for the block to take the current byte.
         end else if (send_gap > 0) begin
            send_gap--;
            req_bus.valid <= 1'b0;
         end else if (byte_stream.size() > 0 &&
                      !(byte_stream[0].hold && awaited_verdicts.size() > 0)) begin
            sb = byte_stream.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.data_byte <= sb.data;
            req_bus.last_byte <= sb.fin;
            send_gap = pick_gap(send_quiet);
         end else begin
            // Nothing to send, or a draining pause before the next message.
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Response monitor. Every response taken is compared field by field with
   // the oldest verdict still awaited. Ready is stalled at random.
   int take_gap = 0;
   int take_quiet = 0;

   always @(posedge clock) begin : collect_responses
      echo_result_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         take_gap = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            verdict_tally[rsp_bus.verdict]++;
            if (awaited_verdicts.size() == 0) begin
               $error("unexpected response: verdict %0d ident %h seq %h length %0d",
                      rsp_bus.verdict, rsp_bus.echo_identifier, rsp_bus.echo_sequence,
                      rsp_bus.echo_data_length);
               error_count++;
            end else begin
               want = awaited_verdicts.pop_front();
               responses_checked++;
               if (rsp_bus.verdict !== want.verdict) begin
                  $error("verdict: expected %0d, actual %0d", want.verdict, rsp_bus.verdict);
                  error_count++;
               end
               if (rsp_bus.echo_identifier !== want.ident) begin
                  $error("echo_identifier: expected %h, actual %h",
                         want.ident, rsp_bus.echo_identifier);
                  error_count++;
               end
               if (rsp_bus.echo_sequence !== want.seq) begin
                  $error("echo_sequence: expected %h, actual %h",
                         want.seq, rsp_bus.echo_sequence);
                  error_count++;
               end
               if (rsp_bus.echo_data_length !== want.data_len) begin
                  $error("echo_data_length: expected %0d, actual %0d",
                         want.data_len, rsp_bus.echo_data_length);
                  error_count++;
               end
            end
         end
         if (take_gap > 0) begin
            take_gap--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            take_gap = pick_gap(take_quiet);
         end
      end
   end

   // Stimulus and end of run.
   initial begin : run_messages
      int          r;
      int          len;
      int          random_bytes;
      int          random_msgs;
      logic [7:0]  t;
      logic [7:0]  c;
      req_bus.valid = 1'b0;
      req_bus.data_byte = 8'h00;
      req_bus.last_byte = 1'b0;
      rsp_bus.ready = 1'b0;
      reset = 1'b1;

      // Directed messages: extremes of the fields, every verdict, the length
      // limits on both sides, odd lengths, an all-zero message and pauses that
      // wait for the block to drain.
      queue_message(TYPE_ECHO_REQUEST, 8'd0, 16'h0000, 16'h0000, 8, 1, 0, 0, 0);
      queue_message(TYPE_ECHO_REPLY, 8'd0, 16'hFFFF, 16'hFFFF, 8, 1, 0, 0, 0);
      queue_message(TYPE_ECHO_REQUEST, 8'd0, 16'hA5C3, 16'h0001, 9, 1, 0, 0, 0);
      queue_message(TYPE_ECHO_REPLY, 8'd0, 16'h1234, 16'hFFFE, 13, 1, 0, 0, 0);
      queue_message(TYPE_ECHO_REQUEST, 8'd0, 16'hFFFF, 16'hFFFF, MSG_LIMIT, 1, 0, 0, 1);
      queue_message(TYPE_ECHO_REPLY, 8'd0, 16'h0000, 16'h8000, MSG_LIMIT - 1, 1, 0, 0, 0);
      queue_message(TYPE_ECHO_REQUEST, 8'd0, 16'h0102, 16'h0304, MSG_LIMIT + 1, 1, 0, 0, 0);
      queue_message(TYPE_ECHO_REPLY, 8'd0, 16'h0102, 16'h0304, MSG_LIMIT + 12, 1, 0, 0, 0);
      queue_message(TYPE_ECHO_REQUEST, 8'd0, 16'h0000, 16'h0000, 7, 1, 0, 0, 0);
      queue_message(TYPE_ECHO_REQUEST, 8'd0, 16'h0000, 16'h0000, 1, 0, 0, 0, 0);
      queue_message(TYPE_ECHO_REQUEST, 8'd0, 16'h0000, 16'h0000, 4, 1, 0, 0, 0);
      queue_message(8'd3, 8'd0, 16'h4444, 16'h5555, 8, 1, 0, 0, 0);
      queue_message(8'hFF, 8'hFF, 16'h4444, 16'h5555, 10, 1, 0, 0, 0);
      queue_message(TYPE_ECHO_REQUEST, 8'd1, 16'h7777, 16'h8888, 8, 1, 0, 0, 0);
      queue_message(TYPE_ECHO_REPLY, 8'hFF, 16'h7777, 16'h8888, 11, 1, 0, 0, 0);
      queue_message(TYPE_ECHO_REQUEST, 8'd0, 16'h1111, 16'h2222, 20, 1, 1, 0, 0);
      queue_message(TYPE_ECHO_REPLY, 8'd0, 16'h0000, 16'h0000, 8, 0, 0, 1, 0);
      queue_message(TYPE_ECHO_REPLY, 8'd0, 16'h0000, 16'h0000, 12, 1, 0, 1, 1);
      queue_message(8'd1, 8'd0, 16'h0000, 16'h0000, 9, 0, 0, 0, 0);

      // Random messages: mostly well-formed echo traffic with random content,
      // mixed with foreign types, nonzero codes, short frames and bad sums.
      random_bytes = 0;
      random_msgs = 0;
      while (random_bytes < 1200 || random_msgs < 40) begin
         r = $urandom_range(0, 9);
         t = (r < 4) ? TYPE_ECHO_REQUEST : (r < 8) ? TYPE_ECHO_REPLY : 8'($urandom);
         c = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
         r = $urandom_range(0, 99);
         if (r < 5) len = $urandom_range(1, HEADER_BYTES - 1);
         else if (r < 80) len = $urandom_range(HEADER_BYTES, 40);
         else if (r < 96) len = $urandom_range(41, 200);
         else len = $urandom_range(201, 500);
         queue_message(t, c, 16'($urandom), 16'($urandom), len,
                       $urandom_range(0, 99) >= 8, $urandom_range(0, 99) < 8,
                       $urandom_range(0, 99) < 1, $urandom_range(0, 99) < 3);
         random_bytes += len;
         random_msgs++;
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (byte_stream.size() != 0 || req_bus.valid) @(posedge clock);
      while (awaited_verdicts.size() != 0) @(posedge clock);
      // The response path is two stages deep; give it room to show strays.
      repeat (20) @(posedge clock);

      if (awaited_verdicts.size() != 0) begin
         $error("%0d verdicts never arrived", awaited_verdicts.size());
         error_count++;
      end
      $display("tb: %0d bytes in %0d messages driven, %0d responses checked",
               bytes_accepted, msgs_accepted, responses_checked);
      $display("tb: malformed %0d, unsupported %0d, echo request %0d, echo reply %0d",
               verdict_tally[VERDICT_MALFORMED], verdict_tally[VERDICT_UNSUPPORTED],
               verdict_tally[VERDICT_REQUEST], verdict_tally[VERDICT_REPLY]);
      if (error_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run of this stimulus.
   initial begin
      #10_000_000;
      $display("tb: errors");
      $finish;
   end

endmodule
